[rtl/core/s128_pkg.sv]
// shared types and constants for the signed 128-bit alu
package s128_pkg;
  localparam int unsigned WordW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned CntW  = 7;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_REM = 3'd4;
  localparam logic [2:0] FN_CMP = 3'd5;

  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_LT = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture operands, form magnitudes
    logic step;   // one multiply or divide iteration
    logic fin;    // form the final result into the output register
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic iter;   // the word needs the iterative unit
    logic last;   // iteration counter at its final step
  } ctl_sts_t;
endpackage

[rtl/core/s128_ctrl.sv]
// controller state machine for the signed 128-bit alu
module s128_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output s128_pkg::ctl_cmd_t  cmd,
  input  s128_pkg::ctl_sts_t  sts
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       done_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_PREP;
      ST_PREP: state_nxt = sts.iter ? ST_RUN : ST_FIN;
      ST_RUN:  if (sts.last) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == ST_FIN);
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign done     = done_r;
  assign cmd.load = (state_r == ST_IDLE) && start;
  assign cmd.step = (state_r == ST_RUN);
  assign cmd.fin  = (state_r == ST_FIN);
endmodule

[rtl/core/s128_dp.sv]
// datapath: operand registers, shift-add multiplier, restoring divider
module s128_dp (
  input  logic               clk,
  input  s128_pkg::ctl_cmd_t cmd,
  output s128_pkg::ctl_sts_t sts,
  input  logic [2:0]         func,
  input  logic [63:0]        a_high,
  input  logic [63:0]        a_low,
  input  logic [63:0]        b_high,
  input  logic [63:0]        b_low,
  output logic [63:0]        result_high,
  output logic [63:0]        result_low,
  output logic [1:0]         order,
  output logic               div_zero
);
  localparam int unsigned W = s128_pkg::WordW;

  logic [2:0]                  func_r;
  logic [W-1:0]                a_r, b_r;
  logic [W-1:0]                mb_r;         // divisor / multiplicand magnitude
  logic [W-1:0]                acc_r;        // product or remainder
  logic [W-1:0]                sh_r;         // multiplier / dividend-quotient
  logic [s128_pkg::CntW-1:0]   cnt_r;
  logic                        prep_r;
  logic [63:0]                 rh_r, rl_r;
  logic [1:0]                  ord_r;
  logic                        dz_r;

  logic [W-1:0] a_in, b_in, rem_sh, rem_sub;
  logic         sa, sb, bz, is_mul, is_div, rem_ge;
  logic [W-1:0] res;
  logic [1:0]   ord;

  assign a_in = {a_high, a_low};
  assign b_in = {b_high, b_low};
  assign sa   = a_r[W-1];
  assign sb   = b_r[W-1];
  assign bz   = (b_r == '0);
  assign is_mul = (func_r == s128_pkg::FN_MUL);
  assign is_div = (func_r == s128_pkg::FN_DIV) || (func_r == s128_pkg::FN_REM);

  assign sts.iter = is_mul || (is_div && !bz);
  assign sts.last = (cnt_r == '1);

  // divider step: shift in next dividend bit, trial subtract
  assign rem_sh  = {acc_r[W-2:0], sh_r[W-1]};
  assign rem_sub = rem_sh - mb_r;
  assign rem_ge  = (acc_r[W-1] == 1'b1) || (rem_sh >= mb_r);

  // signed compare
  always_comb begin
    if (a_r == b_r) ord = s128_pkg::ORD_EQ;
    else if (sa != sb) ord = sa ? s128_pkg::ORD_LT : s128_pkg::ORD_GT;
    else ord = (a_r > b_r) ? s128_pkg::ORD_GT : s128_pkg::ORD_LT;
  end

  // final result select
  always_comb begin
    res = '0;
    case (func_r)
      s128_pkg::FN_ADD: res = a_r + b_r;
      s128_pkg::FN_SUB: res = a_r - b_r;
      s128_pkg::FN_MUL: res = (sa != sb) ? (~acc_r + 1'b1) : acc_r;
      s128_pkg::FN_DIV: res = bz ? '0 : ((sa != sb) ? (~sh_r + 1'b1) : sh_r);
      s128_pkg::FN_REM: res = bz ? a_r : (sa ? (~acc_r + 1'b1) : acc_r);
      default:          res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prep_r <= cmd.load;
    if (cmd.load) begin
      func_r <= func;
      a_r    <= a_in;
      b_r    <= b_in;
    end
    // magnitudes, formed in the cycle after capture
    if (prep_r) begin
      mb_r  <= sb ? (~b_r + 1'b1) : b_r;
      acc_r <= '0;
      sh_r  <= sa ? (~a_r + 1'b1) : a_r;
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (is_mul) begin
        // shift-add, msb of multiplier first
        acc_r <= {acc_r[W-2:0], 1'b0} + (sh_r[W-1] ? mb_r : '0);
        sh_r  <= {sh_r[W-2:0], 1'b0};
      end else begin
        acc_r <= rem_ge ? rem_sub : rem_sh;
        sh_r  <= {sh_r[W-2:0], rem_ge};
      end
    end
    if (cmd.fin) begin
      rh_r  <= res[W-1:64];
      rl_r  <= res[63:0];
      ord_r <= (func_r == s128_pkg::FN_CMP) ? ord : s128_pkg::ORD_EQ;
      dz_r  <= is_div && bz;
    end
  end

  assign result_high = rh_r;
  assign result_low  = rl_r;
  assign order       = ord_r;
  assign div_zero    = dz_r;
endmodule

[rtl/core/signed_int128_alu_unit.sv]
// top level of the signed 128-bit integer alu
// sequence: the accepting edge captures operands, PREP forms magnitudes, FIN registers the result
// and the strobe is registered from FIN; add, subtract, compare, unused codes and zero divisor go
// from PREP to FIN, multiply, divide and remainder pass through RUN; handshake: one word at a time,
// busy drops in the strobe cycle, so a new word can be taken in that cycle; RUN is the 128-step shift loop
// reset: synchronous active-low rst_n returns the controller to idle; no result is pending
module signed_int128_alu_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_a_high,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_b_high,
  input  logic [63:0] in_b_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic [1:0]  out_order,
  output logic        out_div_zero
);
  s128_pkg::ctl_cmd_t cmd;
  s128_pkg::ctl_sts_t sts;

  s128_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(out_valid), .cmd(cmd), .sts(sts)
  );

  s128_dp u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .func(in_func),
    .a_high(in_a_high), .a_low(in_a_low), .b_high(in_b_high), .b_low(in_b_low),
    .result_high(out_result_high), .result_low(out_result_low),
    .order(out_order), .div_zero(out_div_zero)
  );
endmodule

[rtl/core/s128_chk.sv]
// port-level checker for the signed 128-bit alu
module s128_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_order,
  input logic        out_div_zero
);
  // a word taken makes the unit busy
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after start");
  // result strobe comes while idle again and not twice in a row
  a_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  // order code 3 never appears
  a_ord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_order != 2'd3)) else $error("bad order code");
  // compare outcome and divide flag are exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_order == 2'd0) else $error("flag clash");
  // strobe only follows a busy cycle
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("spurious result");
endmodule

bind signed_int128_alu_unit s128_chk u_s128_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_order(out_order), .out_div_zero(out_div_zero)
);

[dv/signed_int128_alu_unit_test.sv]
// testbench for the signed 128-bit integer alu: queue-fed driver, monitor, predictor
`timescale 1ns / 1ps
module signed_int128_alu_unit_test;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 140;
  localparam int unsigned RandWords = 1500;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] a_high;
    logic [63:0] a_low;
    logic [63:0] b_high;
    logic [63:0] b_low;
  } alu_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [1:0]  order;
    logic        div_zero;
  } alu_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic [63:0] in_a_high, in_a_low, in_b_high, in_b_low;
  logic        out_valid;
  logic [63:0] out_result_high, out_result_low;
  logic [1:0]  out_order;
  logic        out_div_zero;

  alu_word_t pending_words[$];
  alu_res_t  expected_results[$];
  int unsigned send_idle_pct;
  bit          hold_for_drain;
  bit          stim_done;
  int unsigned errors;
  int unsigned quiet_cycles;

  signed_int128_alu_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_a_high(in_a_high), .in_a_low(in_a_low),
    .in_b_high(in_b_high), .in_b_low(in_b_low),
    .out_valid(out_valid), .out_result_high(out_result_high),
    .out_result_low(out_result_low), .out_order(out_order),
    .out_div_zero(out_div_zero)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // alu behavior at 128 bits
  function automatic alu_res_t alu_compute(alu_word_t w);
    logic [127:0] a, b, ma, mb, q, r, v;
    logic         sa, sb;
    alu_res_t     res;
    a = {w.a_high, w.a_low};
    b = {w.b_high, w.b_low};
    sa = a[127];
    sb = b[127];
    ma = sa ? -a : a;
    mb = sb ? -b : b;
    v = '0;
    res = '0;
    case (w.func)
      s128_pkg::FN_ADD: v = a + b;
      s128_pkg::FN_SUB: v = a - b;
      s128_pkg::FN_MUL: begin
        v = ma * mb;
        if (sa != sb) v = -v;
      end
      s128_pkg::FN_DIV, s128_pkg::FN_REM: begin
        if (b == '0) begin
          res.div_zero = 1'b1;
          v = (w.func == s128_pkg::FN_DIV) ? '0 : a;
        end else begin
          q = ma / mb;
          r = ma % mb;
          if (w.func == s128_pkg::FN_DIV) v = (sa != sb) ? -q : q;
          else v = sa ? -r : r;
        end
      end
      s128_pkg::FN_CMP: begin
        if (a == b) res.order = s128_pkg::ORD_EQ;
        else if ($signed(a) < $signed(b)) res.order = s128_pkg::ORD_LT;
        else res.order = s128_pkg::ORD_GT;
      end
      default: v = '0;
    endcase
    res.result_high = v[127:64];
    res.result_low = v[63:0];
    return res;
  endfunction

  // operand half with bias toward edge values
  function automatic logic [63:0] pick_half();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_word_t random_word();
    alu_word_t w;
    w.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
    w.a_high = pick_half();
    w.a_low = pick_half();
    if ($urandom_range(0, 3) == 0) begin
      // small divisors: high half all zeros or all ones, low half random
      w.b_high = $urandom_range(0, 1) ? '1 : '0;
      w.b_low = {$urandom, $urandom};
    end else begin
      w.b_high = pick_half();
      w.b_low = pick_half();
    end
    if ($urandom_range(0, 15) == 0) {w.b_high, w.b_low} = {w.a_high, w.a_low};
    return w;
  endfunction

  task automatic add_word(logic [2:0] f, logic [127:0] a, logic [127:0] b);
    alu_word_t w;
    w.func = f;
    {w.a_high, w.a_low} = a;
    {w.b_high, w.b_low} = b;
    pending_words.push_back(w);
  endtask

  task automatic wait_queue_empty();
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [127:0] max_neg, max_pos, all_one;
    max_neg = {1'b1, 127'd0};
    max_pos = {1'b0, {127{1'b1}}};
    all_one = '1;
    rst_n = 1'b0;
    send_idle_pct = 34;
    hold_for_drain = 1'b0;
    stim_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    add_word(s128_pkg::FN_ADD, max_pos, 128'd1);
    add_word(s128_pkg::FN_ADD, all_one, all_one);
    add_word(s128_pkg::FN_SUB, max_neg, 128'd1);
    add_word(s128_pkg::FN_SUB, 128'd0, max_neg);
    add_word(s128_pkg::FN_MUL, all_one, all_one);
    add_word(s128_pkg::FN_MUL, max_neg, all_one);
    add_word(s128_pkg::FN_MUL, max_pos, max_pos);
    add_word(s128_pkg::FN_DIV, max_neg, all_one);
    add_word(s128_pkg::FN_DIV, 128'd7, 128'd0);
    add_word(s128_pkg::FN_DIV, -128'sd7, 128'd2);
    add_word(s128_pkg::FN_DIV, max_pos, 128'd1);
    add_word(s128_pkg::FN_REM, -128'sd7, 128'd2);
    add_word(s128_pkg::FN_REM, 128'd7, -128'sd2);
    add_word(s128_pkg::FN_REM, max_neg, 128'd0);
    add_word(s128_pkg::FN_REM, max_neg, all_one);
    add_word(s128_pkg::FN_CMP, max_neg, max_pos);
    add_word(s128_pkg::FN_CMP, max_pos, max_neg);
    add_word(s128_pkg::FN_CMP, all_one, all_one);
    add_word(s128_pkg::FN_CMP, 128'd5, all_one);
    add_word(3'd6, all_one, all_one);
    add_word(3'd7, max_neg, max_pos);
    wait_queue_empty();

    // pause until the block has drained
    hold_for_drain = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    hold_for_drain = 1'b0;

    for (int unsigned i = 0; i < RandWords; i++) begin
      if (i == RandWords / 3) begin
        wait_queue_empty();
        send_idle_pct = 59;
      end else if (i == 2 * RandWords / 3) begin
        wait_queue_empty();
        send_idle_pct = 0;
      end
      pending_words.push_back(random_word());
    end
    wait_queue_empty();
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_func <= '0;
      in_a_high <= '0;
      in_a_low <= '0;
      in_b_high <= '0;
      in_b_low <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(alu_compute({in_func, in_a_high, in_a_low,
                                                in_b_high, in_b_low}));
        void'(pending_words.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_words.size() > (start && !busy ? 0 : 0) && !hold_for_drain &&
            pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          start <= 1'b1;
          {in_func, in_a_high, in_a_low, in_b_high, in_b_low} <= pending_words[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    alu_res_t got, want;
    if (rst_n && out_valid) begin
      got = {out_result_high, out_result_low, out_order, out_div_zero};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word: actual %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.result_high !== want.result_high) begin
          $display("%0t: result_high expected %h actual %h", $time,
                   want.result_high, got.result_high);
          errors++;
        end
        if (got.result_low !== want.result_low) begin
          $display("%0t: result_low expected %h actual %h", $time,
                   want.result_low, got.result_low);
          errors++;
        end
        if (got.order !== want.order) begin
          $display("%0t: order expected %0d actual %0d", $time, want.order, got.order);
          errors++;
        end
        if (got.div_zero !== want.div_zero) begin
          $display("%0t: div_zero expected %0d actual %0d", $time,
                   want.div_zero, got.div_zero);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    errors = 0;
    quiet_cycles = 0;
    @(posedge clk);
    while (!(stim_done && expected_results.size() == 0) && quiet_cycles < WatchLimit) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("signed_int128_alu_unit_test NOT OK");
    end else begin
      repeat (DrainCycles) @(posedge clk);
      if (errors == 0) $display("signed_int128_alu_unit_test OK");
      else $display("signed_int128_alu_unit_test NOT OK");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/s128_pkg.sv
rtl/core/s128_ctrl.sv
rtl/core/s128_dp.sv
rtl/core/signed_int128_alu_unit.sv
rtl/core/s128_chk.sv
dv/signed_int128_alu_unit_test.sv
